>>> hw/rtl/favc_pkg.sv
// Shared types and constants for the finger approach velocity controller.
package favc_pkg;

  localparam int unsigned NumSlots   = 3;
  localparam int unsigned PosW       = 14;
  localparam int unsigned ForceW     = 12;
  localparam int unsigned FingerW    = 2;
  localparam int unsigned VelW       = 11;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 14;
  localparam int unsigned ProdW      = 26;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = 1;
  localparam int unsigned FifoCntW   = 2;

  localparam logic [PosW-1:0]   StopBand   = 14'd40;
  localparam logic [ProdW-1:0]  GainSq     = 26'd2500;
  localparam logic [VelW-1:0]   VelMin     = 11'd80;
  localparam logic [VelW-1:0]   VelMax     = 11'd960;
  localparam logic [VelW-1:0]   VelClose   = 11'd880;
  localparam logic [ForceW-1:0] LimitReset = 12'd150;
  // Highest power of four that the product can reach: 2500 * 16383 < 2^26.
  localparam logic [ProdW-1:0]  RootStart  = 26'd1 << 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRIP_MODE = 3'd0,
    CFG_TARGET_A  = 3'd1,
    CFG_TARGET_B  = 3'd2,
    CFG_TARGET_C  = 3'd3,
    CFG_LIMIT_A   = 3'd4,
    CFG_LIMIT_B   = 3'd5,
    CFG_LIMIT_C   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_SQRT  = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_ROOT = 2'd2,
    BK_DONE = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [FingerW-1:0]  finger;
    cmd_kind_e           kind;
    logic                neg;
    logic [PosW-1:0]     mag;
    logic                fstop;
    logic [NumSlots-1:0] done_mask;
    logic                all_stop;
  } cmd_t;

endpackage

>>> hw/rtl/finger_approach_velocity_controller_core.sv
// Top level of the finger approach velocity controller.
//
//   Channel  Handshake                  Beat contents
//   cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in_valid_i  / in_ready_o   finger, position, force, restart, halt
//   out      out_valid_o / out_ready_i  finger, velocity, stop, done mask, all stop
//
// A sample that needs no square root passes through the queue, the back end command register
// and the output register; a move-mode sample that needs a velocity also goes through the
// scaling multiply and the bit-serial square root in the back end.
// The back end works on one sample at a time; the two-entry queue keeps the input open
// while it is busy. Reset clears the done mask and restores the register reset values.
// A stalled output holds the back end, which then fills the queue and drops in_ready_o.
module finger_approach_velocity_controller_core import favc_pkg::*; #(
  parameter int unsigned NUM_FINGERS = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FingerW-1:0]     finger_i,
  input  logic [PosW-1:0]        position_i,
  input  logic [ForceW-1:0]      force_req_i,
  input  logic                   restart_i,
  input  logic                   halt_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [FingerW-1:0]     finger_out_o,
  output logic signed [VelW-1:0] velocity_o,
  output logic                   finger_stop_o,
  output logic [NumSlots-1:0]    done_mask_o,
  output logic                   all_stop_o
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  favc_front #(
    .NUM_FINGERS(NUM_FINGERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .finger_i    (finger_i),
    .position_i  (position_i),
    .force_req_i (force_req_i),
    .restart_i   (restart_i),
    .halt_i      (halt_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  favc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  favc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .finger_out_o  (finger_out_o),
    .velocity_o    (velocity_o),
    .finger_stop_o (finger_stop_o),
    .done_mask_o   (done_mask_o),
    .all_stop_o    (all_stop_o)
  );

endmodule

>>> hw/rtl/favc_front.sv
// Front end: configuration registers, done mask and classification of each sample.
module favc_front import favc_pkg::*; #(
  parameter int unsigned NUM_FINGERS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FingerW-1:0]  finger_i,
  input  logic [PosW-1:0]     position_i,
  input  logic [ForceW-1:0]   force_req_i,
  input  logic                restart_i,
  input  logic                halt_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o
);

  localparam int unsigned NfEff = (NUM_FINGERS < NumSlots) ? NUM_FINGERS : NumSlots;
  localparam logic [NumSlots-1:0] FullMask = NumSlots'((1 << NfEff) - 1);
  // With more fingers than slots the mask is never treated as full.
  localparam bit FullReachable = (NUM_FINGERS <= NumSlots);

  logic                grip_mode_q;
  logic [PosW-1:0]     target_q [NumSlots];
  logic [ForceW-1:0]   limit_q  [NumSlots];
  logic [NumSlots-1:0] mask_q, mask_d;

  logic [NumSlots-1:0] mask_base;
  logic                base_full;
  logic                finger_ok;
  logic [PosW-1:0]     tgt;
  logic [ForceW-1:0]   lim;
  logic                neg;
  logic [PosW-1:0]     mag;
  logic [NumSlots-1:0] finger_bit;
  cmd_t                cmd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && in_ready_o;
  assign q_cmd_o     = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grip_mode_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        target_q[i] <= '0;
        limit_q[i]  <= LimitReset;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRIP_MODE: grip_mode_q <= cfg_data_i[0];
        CFG_TARGET_A:  target_q[0] <= cfg_data_i;
        CFG_TARGET_B:  target_q[1] <= cfg_data_i;
        CFG_TARGET_C:  target_q[2] <= cfg_data_i;
        CFG_LIMIT_A:   limit_q[0]  <= cfg_data_i[ForceW-1:0];
        CFG_LIMIT_B:   limit_q[1]  <= cfg_data_i[ForceW-1:0];
        CFG_LIMIT_C:   limit_q[2]  <= cfg_data_i[ForceW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (q_push_o) begin
      mask_q <= mask_d;
    end
  end

  always_comb begin
    mask_base  = restart_i ? '0 : mask_q;
    base_full  = FullReachable && ((mask_base & FullMask) == FullMask);
    finger_ok  = (32'(finger_i) < NUM_FINGERS) && (32'(finger_i) < NumSlots);
    tgt        = '0;
    lim        = '0;
    unique case (finger_i)
      2'd0: begin tgt = target_q[0]; lim = limit_q[0]; end
      2'd1: begin tgt = target_q[1]; lim = limit_q[1]; end
      2'd2: begin tgt = target_q[2]; lim = limit_q[2]; end
      default: ;
    endcase
    neg        = tgt < position_i;
    mag        = neg ? (position_i - tgt) : (tgt - position_i);
    finger_bit = NumSlots'(1) << finger_i;

    mask_d        = mask_base;
    cmd.finger    = finger_i;
    cmd.kind      = KIND_ZERO;
    cmd.neg       = neg;
    cmd.mag       = mag;
    cmd.fstop     = 1'b0;

    if (halt_i || base_full) begin
      cmd.fstop = 1'b1;
    end else if (finger_ok) begin
      if (!grip_mode_q) begin
        if (mag <= StopBand) begin
          cmd.fstop = 1'b1;
          mask_d    = mask_base | finger_bit;
        end else begin
          cmd.kind = KIND_SQRT;
        end
      end else begin
        if (force_req_i > lim) begin
          cmd.fstop = 1'b1;
          mask_d    = mask_base | finger_bit;
        end else begin
          cmd.kind = KIND_CLOSE;
        end
      end
      mask_d = mask_d & FullMask;
    end

    cmd.done_mask = mask_d;
    cmd.all_stop  = halt_i || (FullReachable && ((mask_d & FullMask) == FullMask));
  end

endmodule

>>> hw/rtl/favc_fifo.sv
// Two-entry command queue between the front end and the velocity back end.
module favc_fifo import favc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  assign full_o    = (count_q == FifoCntW'(FifoDepth));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("command queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from an empty queue");

endmodule

>>> hw/rtl/favc_back.sv
// Back end: scaling multiply, bit-serial square root, clamp and the output register.
module favc_back import favc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  cmd_t                      q_cmd_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [FingerW-1:0]        finger_out_o,
  output logic signed [VelW-1:0]    velocity_o,
  output logic                      finger_stop_o,
  output logic [NumSlots-1:0]       done_mask_o,
  output logic                      all_stop_o
);

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [ProdW-1:0]    rem_q, rem_d;
  logic [ProdW-1:0]    root_q, root_d;
  logic [ProdW-1:0]    bit_q, bit_d;

  logic                out_valid_q, out_valid_d;
  logic [FingerW-1:0]  out_finger_q, out_finger_d;
  logic [VelW-1:0]     out_vel_q, out_vel_d;
  logic                out_fstop_q, out_fstop_d;
  logic [NumSlots-1:0] out_mask_q, out_mask_d;
  logic                out_all_q, out_all_d;

  logic [ProdW:0]      trial;
  logic [VelW-1:0]     vel_mag;
  logic                out_free;

  assign out_valid_o   = out_valid_q;
  assign finger_out_o  = out_finger_q;
  assign velocity_o    = out_vel_q;
  assign finger_stop_o = out_fstop_q;
  assign done_mask_o   = out_mask_q;
  assign all_stop_o    = out_all_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rem_q        <= rem_d;
    root_q       <= root_d;
    bit_q        <= bit_d;
    out_finger_q <= out_finger_d;
    out_vel_q    <= out_vel_d;
    out_fstop_q  <= out_fstop_d;
    out_mask_q   <= out_mask_d;
    out_all_q    <= out_all_d;
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    rem_d        = rem_q;
    root_d       = root_q;
    bit_d        = bit_q;
    out_finger_d = out_finger_q;
    out_vel_d    = out_vel_q;
    out_fstop_d  = out_fstop_q;
    out_mask_d   = out_mask_q;
    out_all_d    = out_all_q;
    q_pop_o      = 1'b0;
    out_free     = !out_valid_q || out_ready_i;
    out_valid_d  = out_valid_q && !out_ready_i;
    trial        = {1'b0, root_q} + {1'b0, bit_q};

    if (root_q > ProdW'(VelMax)) begin
      vel_mag = VelMax;
    end else if (root_q < ProdW'(VelMin)) begin
      vel_mag = VelMin;
    end else begin
      vel_mag = root_q[VelW-1:0];
    end

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = (q_cmd_i.kind == KIND_SQRT) ? BK_MUL : BK_DONE;
        end
      end
      BK_MUL: begin
        rem_d   = {{(ProdW-PosW){1'b0}}, cmd_q.mag} * GainSq;
        root_d  = '0;
        bit_d   = RootStart;
        state_d = BK_ROOT;
      end
      BK_ROOT: begin
        // One result bit per cycle, two bits of the radicand consumed.
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[ProdW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_finger_d = cmd_q.finger;
          out_fstop_d  = cmd_q.fstop;
          out_mask_d   = cmd_q.done_mask;
          out_all_d    = cmd_q.all_stop;
          unique case (cmd_q.kind)
            KIND_CLOSE: out_vel_d = VelClose;
            KIND_SQRT:  out_vel_d = cmd_q.neg ? VelW'(-vel_mag) : vel_mag;
            default:    out_vel_d = '0;
          endcase
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  a_stop_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fstop_q) |-> (out_vel_q == '0))
    else $error("stopped finger carries a non-zero velocity");

  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_vel_q) <= $signed(VelMax) &&
                     $signed(out_vel_q) >= -$signed(VelMax)))
    else $error("velocity outside its clamp range");

  a_root_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROOT) |-> $onehot(bit_q))
    else $error("square root step mark is not one-hot");

  a_root_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROOT) |=> (state_q == BK_ROOT || state_q == BK_DONE))
    else $error("square root left for an unexpected state");

endmodule
